@@ src/text_console_writer_macros.svh @@
// assertion macros for the checker of the console writer
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CTW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console writer check failed");

// next-cycle implication, disabled while in reset
`define CTW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console writer check failed");

`endif

@@ src/ctw_pkg.sv @@
`default_nettype none

package ctw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    // character codes with special meaning
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;

    // operation codes
    localparam logic [1:0] OP_PUT_CURSOR = 2'd0;
    localparam logic [1:0] OP_PUT_AT     = 2'd1;
    localparam logic [1:0] OP_READ       = 2'd2;
    localparam logic [1:0] OP_CLEAR      = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [6:0] column;
        logic [4:0] row;
    } ctw_cmd_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_line;
    } ctw_res_t;

    // access strobes from the sequencer to the cell store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ctw_mem_ctl_t;

    // attribute in the high byte, character in the low byte
    function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [7:0] attr);
        return {attr, ch};
    endfunction

endpackage

`default_nettype wire

@@ src/text_console_writer.sv @@
// Text-mode console writer: a ROWS x COLUMNS screen of 16-bit cells (attribute
// in the high byte, character in the low byte) held in one single-port memory
// with a registered read, plus a text cursor. Each command transaction yields
// exactly one result transaction. With the result side free, a character, a
// positioned write, a newline, a carriage return, a scroll, a screen clear and
// a read of an empty row or an off-screen position pass S_IDLE (accept) and
// then S_EXEC (execute); a read of a row that holds data also passes through
// S_READ for the registered memory read. Scrolling moves a row base pointer
// instead of copying rows, and clearing only marks rows empty, so the first
// write into a row that was cleared, scrolled out or untouched since reset is
// preceded by S_SWEEP, in which the sequencer zeroes that row one cell per
// cycle through the memory port. Empty rows read as zero. There is no clearing
// pass after reset. A finished result waits in an output register and one new
// command can be taken while it does.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = ctw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ctw_pkg::ROWS_DEFAULT
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cmd_valid,
    output logic                   cmd_stall,
    input  wire ctw_pkg::ctw_cmd_t cmd,
    output logic                   res_valid,
    input  wire                    res_stall,
    output ctw_pkg::ctw_res_t      res
);
    import ctw_pkg::*;

    localparam int AW = $clog2(ROWS) + $clog2(COLUMNS);

    ctw_mem_ctl_t  mem_ctl;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wdata;
    logic [15:0]   mem_rdata;

    // command sequencer, cursor and row bookkeeping
    ctw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // screen cell memory
    ctw_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_store (
        .clk       (clk),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

@@ src/ctw_store.sv @@
`default_nettype none

module ctw_store #(
    parameter int COLUMNS = ctw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ctw_pkg::ROWS_DEFAULT
) (
    input  wire                       clk,
    input  wire ctw_pkg::ctw_mem_ctl_t mem_ctl,
    input  wire [$clog2(ROWS)+$clog2(COLUMNS)-1:0] mem_addr,
    input  wire [15:0]                mem_wdata,
    output logic [15:0]               mem_rdata
);
    import ctw_pkg::*;

    localparam int AW    = $clog2(ROWS) + $clog2(COLUMNS);
    localparam int DEPTH = 1 << AW;

    // one physical row per 2**CW cells, single port
    logic [15:0] cells [DEPTH];
    logic [15:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            cells[mem_addr] <= mem_wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rdata_reg <= cells[mem_addr];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/ctw_ctrl.sv @@
`default_nettype none

module ctw_ctrl #(
    parameter int COLUMNS = ctw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ctw_pkg::ROWS_DEFAULT
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cmd_valid,
    output logic                       cmd_stall,
    input  wire ctw_pkg::ctw_cmd_t     cmd,
    output logic                       res_valid,
    input  wire                        res_stall,
    output ctw_pkg::ctw_res_t          res,
    output ctw_pkg::ctw_mem_ctl_t      mem_ctl,
    output logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0] mem_addr,
    output logic [15:0]                mem_wdata,
    input  wire [15:0]                 mem_rdata
);
    import ctw_pkg::*;

    localparam int CW  = $clog2(COLUMNS);
    localparam int RW  = $clog2(ROWS);
    localparam int RW1 = RW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;

    logic [2:0]      state_reg, state_next;
    ctw_cmd_t        req_reg, req_next;
    logic [CW-1:0]   cur_col_reg, cur_col_next;
    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [RW-1:0]   base_reg, base_next;
    logic [ROWS-1:0] row_valid_reg, row_valid_next;
    logic [RW-1:0]   sweep_row_reg, sweep_row_next;
    logic [CW-1:0]   sweep_col_reg, sweep_col_next;
    logic            res_valid_reg, res_valid_next;
    ctw_res_t        res_reg, res_next;

    logic            out_free;
    logic            in_range;
    logic            is_nl;
    logic            is_cr;
    logic            needs_write;
    logic [CW-1:0]   tcol;
    logic [RW-1:0]   lrow;
    logic [RW:0]     row_sum;
    logic [RW-1:0]   prow;
    logic [15:0]     cell_word;
    logic [CW-1:0]   adv_col;
    logic [RW-1:0]   adv_row;
    logic            adv_scroll;
    logic            emit;
    logic [15:0]     emit_data;

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_free  = !res_valid_reg || !res_stall;

    // decode of the held transaction
    always_comb
    begin
        in_range = (32'(req_reg.column) < 32'(COLUMNS)) && (32'(req_reg.row) < 32'(ROWS));
        is_nl    = (req_reg.char_code == CH_NEWLINE);
        is_cr    = (req_reg.char_code == CH_RETURN);
        needs_write = ((req_reg.opcode == OP_PUT_CURSOR) && !is_nl && !is_cr)
                   || ((req_reg.opcode == OP_PUT_AT) && in_range);
        cell_word = make_cell(req_reg.char_code, req_reg.color);
        if (req_reg.opcode == OP_PUT_CURSOR)
        begin
            tcol = cur_col_reg;
            lrow = cur_row_reg;
        end
        else
        begin
            tcol = CW'(req_reg.column);
            lrow = RW'(req_reg.row);
        end
    end

    // logical row to physical row through the scroll base
    always_comb
    begin
        row_sum = {1'b0, lrow} + {1'b0, base_reg};
        if (row_sum >= RW1'(ROWS))
        begin
            prow = RW'(row_sum - RW1'(ROWS));
        end
        else
        begin
            prow = RW'(row_sum);
        end
    end

    // cursor movement for put at cursor
    always_comb
    begin
        adv_col    = cur_col_reg;
        adv_row    = cur_row_reg;
        adv_scroll = 1'b0;
        if (is_cr)
        begin
            adv_col = '0;
        end
        else if (is_nl || (cur_col_reg == CW'(COLUMNS - 1)))
        begin
            adv_col = '0;
            if (cur_row_reg == RW'(ROWS - 1))
            begin
                adv_scroll = 1'b1;
            end
            else
            begin
                adv_row = cur_row_reg + RW'(1);
            end
        end
        else
        begin
            adv_col = cur_col_reg + CW'(1);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        base_next      = base_reg;
        row_valid_next = row_valid_reg;
        sweep_row_next = sweep_row_reg;
        sweep_col_next = sweep_col_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        mem_ctl        = '0;
        mem_addr       = {prow, tcol};
        mem_wdata      = cell_word;
        emit           = 1'b0;
        emit_data      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    req_next   = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    // a row that was cleared or scrolled out gets zeroed before its first write
                    if (needs_write && !row_valid_reg[prow])
                    begin
                        sweep_row_next = prow;
                        sweep_col_next = '0;
                        state_next     = S_SWEEP;
                    end
                    else
                    begin
                        unique case (req_reg.opcode)
                            OP_PUT_CURSOR:
                            begin
                                if (needs_write)
                                begin
                                    mem_ctl.wr_en = 1'b1;
                                    emit_data     = cell_word;
                                end
                                cur_col_next = adv_col;
                                cur_row_next = adv_row;
                                if (adv_scroll)
                                begin
                                    // old top row becomes the new bottom row, reads as blank
                                    row_valid_next[base_reg] = 1'b0;
                                    if (base_reg == RW'(ROWS - 1))
                                    begin
                                        base_next = '0;
                                    end
                                    else
                                    begin
                                        base_next = base_reg + RW'(1);
                                    end
                                end
                                emit = 1'b1;
                            end
                            OP_PUT_AT:
                            begin
                                if (needs_write)
                                begin
                                    mem_ctl.wr_en = 1'b1;
                                    emit_data     = cell_word;
                                end
                                emit = 1'b1;
                            end
                            OP_READ:
                            begin
                                if (in_range && row_valid_reg[prow])
                                begin
                                    mem_ctl.rd_en = 1'b1;
                                    state_next    = S_READ;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                end
                            end
                            OP_CLEAR:
                            begin
                                row_valid_next = '0;
                                base_next      = '0;
                                cur_col_next   = '0;
                                cur_row_next   = '0;
                                emit           = 1'b1;
                            end
                            default:
                            begin
                                emit = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_SWEEP:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_addr      = {sweep_row_reg, sweep_col_reg};
                mem_wdata     = '0;
                if (sweep_col_reg == CW'(COLUMNS - 1))
                begin
                    row_valid_next[sweep_row_reg] = 1'b1;
                    state_next = S_EXEC;
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + CW'(1);
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    emit_data = mem_rdata;
                    emit      = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // load the result register
        if (emit)
        begin
            res_valid_next         = 1'b1;
            res_next.cell_data     = emit_data;
            res_next.cursor_column = 7'(cur_col_next);
            res_next.cursor_line   = 5'(cur_row_next);
            state_next             = S_IDLE;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            base_reg      <= '0;
            row_valid_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            base_reg      <= base_next;
            row_valid_reg <= row_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        sweep_row_reg <= sweep_row_next;
        sweep_col_reg <= sweep_col_next;
        res_reg       <= res_next;
    end

endmodule

`default_nettype wire

@@ src/ctw_checker.sv @@
`default_nettype none

`include "text_console_writer_macros.svh"

module ctw_checker #(
    parameter int COLUMNS = ctw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ctw_pkg::ROWS_DEFAULT
) (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    cmd_valid,
    input wire                    cmd_stall,
    input wire ctw_pkg::ctw_cmd_t cmd,
    input wire                    res_valid,
    input wire                    res_stall,
    input wire ctw_pkg::ctw_res_t res
);
    import ctw_pkg::*;

    logic cmd_taken;
    logic res_held;

    assign cmd_taken = cmd_valid && !cmd_stall;
    assign res_held  = res_valid && res_stall;

    // a stalled result transaction holds
    `CTW_ASSERT_NXT(a_res_hold, clk, rst_n, res_held, res_valid && $stable(res))

    // a taken command makes the block stall the command side while it runs
    `CTW_ASSERT_NXT(a_cmd_busy, clk, rst_n, cmd_taken, cmd_stall)

    // reported cursor stays on the screen (the row is checked only when ROWS <= 32)
    `CTW_ASSERT_IMP(a_col_range, clk, rst_n, res_valid, 32'(res.cursor_column) < 32'(COLUMNS))
    `CTW_ASSERT_IMP(a_row_range, clk, rst_n, res_valid && (ROWS <= 32),
                    32'(res.cursor_line) < 32'(ROWS))

endmodule

bind text_console_writer ctw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_ctw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import ctw_pkg::*;

    localparam int COLUMNS         = COLUMNS_DEFAULT;
    localparam int ROWS            = ROWS_DEFAULT;
    localparam int SCREEN_CELLS    = COLUMNS * ROWS;
    localparam int RANDOM_ITEMS    = 1350;
    localparam int PRESSURE_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = COLUMNS + 20;
    localparam int REPORT_MAX      = 10;

    // shadow copy of the screen and cursor, plus the results still owed
    class console_shadow;
        logic [15:0] cells [SCREEN_CELLS];
        int unsigned cur_col;
        int unsigned cur_row;
        ctw_res_t    awaited_results [$];
        int unsigned mismatches;

        function new();
            wipe();
            cur_col    = 0;
            cur_row    = 0;
            mismatches = 0;
        endfunction

        function void wipe();
            foreach (cells[i])
                cells[i] = '0;
        endfunction

        // next row, scrolling up when already on the last one
        function void line_feed();
            cur_col = 0;
            if (cur_row == ROWS - 1)
            begin
                for (int i = 0; i < SCREEN_CELLS - COLUMNS; i++)
                    cells[i] = cells[i + COLUMNS];
                for (int i = SCREEN_CELLS - COLUMNS; i < SCREEN_CELLS; i++)
                    cells[i] = '0;
            end
            else
            begin
                cur_row++;
            end
        endfunction

        // update the shadow state for one accepted command transaction
        function void take_command(ctw_cmd_t c);
            ctw_res_t r;
            logic     on_screen;
            r         = '0;
            on_screen = (c.column < COLUMNS) && (c.row < ROWS);
            case (c.opcode)
                OP_PUT_CURSOR:
                begin
                    if (c.char_code == CH_NEWLINE)
                    begin
                        line_feed();
                    end
                    else if (c.char_code == CH_RETURN)
                    begin
                        cur_col = 0;
                    end
                    else
                    begin
                        r.cell_data = {c.color, c.char_code};
                        cells[cur_row * COLUMNS + cur_col] = r.cell_data;
                        cur_col++;
                        if (cur_col >= COLUMNS)
                            line_feed();
                    end
                end
                OP_PUT_AT:
                begin
                    if (on_screen)
                    begin
                        r.cell_data = {c.color, c.char_code};
                        cells[c.row * COLUMNS + c.column] = r.cell_data;
                    end
                end
                OP_READ:
                begin
                    if (on_screen)
                        r.cell_data = cells[c.row * COLUMNS + c.column];
                end
                default:
                begin
                    wipe();
                    cur_col = 0;
                    cur_row = 0;
                end
            endcase
            r.cursor_column = 7'(cur_col);
            r.cursor_line   = 5'(cur_row);
            awaited_results.push_back(r);
        endfunction

        // compare one result transaction with the oldest owed result
        function void check_result(ctw_res_t got);
            ctw_res_t want;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: cell %h col %0d line %0d",
                             got.cell_data, got.cursor_column, got.cursor_line);
                return;
            end
            want = awaited_results.pop_front();
            if (got.cell_data !== want.cell_data ||
                got.cursor_column !== want.cursor_column ||
                got.cursor_line !== want.cursor_line)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result mismatch: expected cell %h col %0d line %0d, got cell %h col %0d line %0d",
                             want.cell_data, want.cursor_column, want.cursor_line,
                             got.cell_data, got.cursor_column, got.cursor_line);
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_stall;
    ctw_cmd_t cmd;
    logic     res_valid;
    logic     res_stall;
    ctw_res_t res;

    logic     calm;
    logic     hold_off_req;
    int       last_put_col;
    int       last_put_row;

    console_shadow shadow = new();

    text_console_writer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            shadow.check_result(res);
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stall bursts and one long hold-off
    initial
    begin : result_sink
        int n;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                n = $urandom_range(1, 4);
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    function automatic ctw_cmd_t make_cmd(logic [1:0] op, logic [7:0] ch, logic [7:0] attr,
                                          int col, int row);
        ctw_cmd_t c;
        c.opcode    = op;
        c.char_code = ch;
        c.color     = attr;
        c.column    = 7'(col);
        c.row       = 5'(row);
        return c;
    endfunction

    // offer one command transaction and wait until it is taken
    task automatic send_command(ctw_cmd_t c);
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        shadow.take_command(c);
    endtask

    // sender idle with junk on the payload; n sets the length of the gap
    task automatic sender_gap(int n);
        repeat (n)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            cmd       <= ctw_cmd_t'($bits(ctw_cmd_t)'($urandom));
        end
    endtask

    // random command for a burst of the given flavor
    function automatic ctw_cmd_t random_command(int mode);
        ctw_cmd_t c;
        int       pick;
        c    = ctw_cmd_t'($bits(ctw_cmd_t)'($urandom));
        pick = $urandom_range(0, 99);
        case (mode)
            // long line of text, wraps at the row end
            1:
            begin
                c.opcode = OP_PUT_CURSOR;
                if (pick < 3)
                    c.char_code = CH_NEWLINE;
            end
            // newline heavy, walks the cursor down and scrolls
            2:
            begin
                c.opcode = OP_PUT_CURSOR;
                if (pick < 50)
                    c.char_code = CH_NEWLINE;
                else if (pick < 60)
                    c.char_code = CH_RETURN;
            end
            // mostly positioned writes and reads, some put at cursor
            3:
            begin
                if (pick < 10)
                    c.opcode = OP_PUT_CURSOR;
                else if (pick < 50)
                    c.opcode = OP_PUT_AT;
                else
                    c.opcode = OP_READ;
            end
            // everything mixed
            default:
            begin
                if (pick < 45)
                    c.opcode = OP_PUT_CURSOR;
                else if (pick < 70)
                    c.opcode = OP_PUT_AT;
                else if (pick < 98)
                    c.opcode = OP_READ;
                else
                    c.opcode = OP_CLEAR;
                if (c.opcode == OP_PUT_CURSOR && $urandom_range(0, 9) == 0)
                    c.char_code = ($urandom_range(0, 1) != 0) ? CH_NEWLINE : CH_RETURN;
            end
        endcase

        // mostly on-screen positions, some anywhere in the field range
        if ((c.opcode == OP_PUT_AT || c.opcode == OP_READ) && $urandom_range(0, 9) != 0)
        begin
            c.column = 7'($urandom_range(0, COLUMNS - 1));
            c.row    = 5'($urandom_range(0, ROWS - 1));
            if (c.opcode == OP_READ)
            begin
                pick = $urandom_range(0, 4);
                if (pick == 0)
                begin
                    c.column = 7'(last_put_col);
                    c.row    = 5'(last_put_row);
                end
                else if (pick == 1)
                begin
                    c.row = 5'(shadow.cur_row);
                end
            end
        end
        if (c.opcode == OP_PUT_AT)
        begin
            last_put_col = c.column;
            last_put_row = c.row;
        end
        return c;
    endfunction

    // field extremes, every operation, control characters, off-screen positions
    task automatic directed_phase();
        send_command(make_cmd(OP_READ,       8'h00, 8'h00,   0,  0));
        send_command(make_cmd(OP_PUT_CURSOR, 8'h41, 8'h07,   0,  0));
        send_command(make_cmd(OP_PUT_CURSOR, 8'h00, 8'hFF,   0,  0));
        send_command(make_cmd(OP_PUT_CURSOR, 8'hFF, 8'h00, 127, 31));
        send_command(make_cmd(OP_PUT_CURSOR, CH_RETURN,  8'hFF, 0, 0));
        send_command(make_cmd(OP_PUT_CURSOR, 8'h42, 8'h1E,   0,  0));
        send_command(make_cmd(OP_PUT_CURSOR, CH_NEWLINE, 8'h00, 0, 0));
        send_command(make_cmd(OP_PUT_CURSOR, 8'h43, 8'h70,   0,  0));
        send_command(make_cmd(OP_PUT_AT,     8'hFF, 8'hFF,  79, 24));
        send_command(make_cmd(OP_PUT_AT,     8'h00, 8'h00,   0,  0));
        send_command(make_cmd(OP_PUT_AT,     8'h55, 8'hAA,  80,  0));
        send_command(make_cmd(OP_PUT_AT,     8'hAA, 8'h55, 127, 31));
        send_command(make_cmd(OP_PUT_AT,     8'h12, 8'h34,   0, 25));
        send_command(make_cmd(OP_READ,       8'h00, 8'h00,  79, 24));
        send_command(make_cmd(OP_READ,       8'h00, 8'h00,  79, 25));
        send_command(make_cmd(OP_READ,       8'h00, 8'h00,  80,  0));
        send_command(make_cmd(OP_READ,       8'hFF, 8'hFF, 127, 31));
        send_command(make_cmd(OP_READ,       8'h00, 8'h00,   0,  1));
        send_command(make_cmd(OP_READ,       8'h00, 8'h00,   1,  0));
        send_command(make_cmd(OP_CLEAR,      8'h00, 8'h00,   0,  0));
        send_command(make_cmd(OP_READ,       8'h00, 8'h00,  79, 24));
        send_command(make_cmd(OP_READ,       8'h00, 8'h00,   0,  0));
        send_command(make_cmd(OP_PUT_CURSOR, 8'h44, 8'h5A,   0,  0));
        send_command(make_cmd(OP_PUT_CURSOR, CH_NEWLINE, 8'h00, 0, 0));
        send_command(make_cmd(OP_PUT_CURSOR, CH_RETURN,  8'h00, 0, 0));
    endtask

    // bursts of random traffic with sender gaps and one long result hold-off
    task automatic random_phase();
        int sent;
        int mode;
        int burst_len;
        logic steady_burst;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode         = $urandom_range(0, 3);
            burst_len    = (mode == 1) ? $urandom_range(60, 170) :
                           (mode == 2) ? $urandom_range(20, 35) : $urandom_range(5, 40);
            steady_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++)
            begin
                if (sent == PRESSURE_AT)
                    hold_off_req = 1'b1;
                calm = (sent >= RANDOM_ITEMS * 85 / 100);
                if (!calm && !steady_burst && $urandom_range(0, 4) == 0)
                    sender_gap($urandom_range(1, 4));
                send_command(random_command(mode));
                sent++;
            end
        end
    endtask

    // reset, stimulus, drain and verdict
    initial
    begin
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd          = '0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        last_put_col = 0;
        last_put_row = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_phase();
        random_phase();
        sender_gap(1);

        while (shadow.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/ctw_pkg.sv
src/ctw_store.sv
src/ctw_ctrl.sv
src/text_console_writer.sv
src/ctw_checker.sv
sim/tb.sv
